FILE: rtl/iam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iam_pkg
// Shared types, character constants and IUPAC decode/encode helpers for the
// allele merge block.
// ----------------------------------------------------------------------------
package iam_pkg;

    typedef logic [7:0] char_t;
    typedef logic [3:0] base_mask_t;

    // ascii characters used by the case and code logic
    localparam char_t CHAR_LC_A = 8'h61;
    localparam char_t CHAR_LC_Z = 8'h7a;
    localparam char_t CHAR_UC_A = 8'h41;
    localparam char_t CHAR_UC_Z = 8'h5a;
    localparam char_t CHAR_UC_C = 8'h43;
    localparam char_t CHAR_UC_G = 8'h47;
    localparam char_t CHAR_UC_T = 8'h54;
    localparam char_t CASE_OFFSET = 8'h20;

    // iupac letter for each base mask (A=8, C=4, G=2, T=1), empty mask is '?'
    localparam char_t CODE_TABLE [16] = '{
        8'h3f, 8'h54, 8'h47, 8'h4b, 8'h43, 8'h59, 8'h53, 8'h42,
        8'h41, 8'h57, 8'h52, 8'h44, 8'h4d, 8'h48, 8'h56, 8'h4e
    };

    // one registered item between the decode and merge stages
    typedef struct packed {
        logic       valid;
        base_mask_t allele_mask;
        char_t      ref_base;
        logic       minus_strand;
        logic       last_char;
    } iam_stage_t;

    // uppercase for a..z only
    function automatic char_t to_upper(input char_t c);
        return (c >= CHAR_LC_A && c <= CHAR_LC_Z) ? c - CASE_OFFSET : c;
    endfunction

    // letter to base mask, anything outside the table gives zero
    function automatic base_mask_t decode_mask(input char_t c);
        char_t      u;
        base_mask_t m;
        u = to_upper(c);
        m = '0;
        for (int i = 1; i < 16; i++)
        begin
            if (CODE_TABLE[i] == u)
                m = m | 4'(i);
        end
        return m;
    endfunction

    // complement strand: A<->T, C<->G (bit reversal)
    function automatic base_mask_t swap_strand(input base_mask_t m);
        return {m[0], m[1], m[2], m[3]};
    endfunction

endpackage

FILE: rtl/iam_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iam_in_if
// Valid/ready channel carrying one allele character with its reference base.
// ----------------------------------------------------------------------------
interface iam_in_if;
    logic                  valid;
    logic                  ready;
    iam_pkg::char_t        allele_char;
    iam_pkg::char_t        ref_base;
    logic                  minus_strand;
    logic                  last_char;

    modport source (output valid, allele_char, ref_base, minus_strand, last_char,
                    input ready);
    modport sink   (input valid, allele_char, ref_base, minus_strand, last_char,
                    output ready);
endinterface

FILE: rtl/iam_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iam_out_if
// Valid/ready channel carrying one merged base with its status flags.
// ----------------------------------------------------------------------------
interface iam_out_if;
    logic                  valid;
    logic                  ready;
    iam_pkg::char_t        merged_base;
    logic                  changed;
    logic                  differing;

    modport source (output valid, merged_base, changed, differing, input ready);
    modport sink   (input valid, merged_base, changed, differing, output ready);
endinterface

FILE: rtl/iam_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iam_decode
// Input register stage: takes a character beat and stores its decoded
// base mask together with the reference base and flags.
// ----------------------------------------------------------------------------
module iam_decode (
    input  logic                clk,
    input  logic                rst_n,
    iam_in_if.sink              allele_in,
    input  logic                take,
    output iam_pkg::iam_stage_t stage
);

    logic               valid_reg;
    iam_pkg::base_mask_t mask_reg;
    iam_pkg::char_t     ref_reg;
    logic               minus_reg;
    logic               last_reg;
    logic               in_ready;

    // stage is free when empty or being drained this cycle
    assign in_ready        = !valid_reg || take;
    assign allele_in.ready = in_ready;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= allele_in.valid;
    end

    // payload, decoded on capture
    always_ff @(posedge clk)
    begin
        if (allele_in.valid && in_ready)
        begin
            mask_reg  <= iam_pkg::decode_mask(allele_in.allele_char);
            ref_reg   <= allele_in.ref_base;
            minus_reg <= allele_in.minus_strand;
            last_reg  <= allele_in.last_char;
        end
    end

    assign stage = '{valid:        valid_reg,
                     allele_mask:  mask_reg,
                     ref_base:     ref_reg,
                     minus_strand: minus_reg,
                     last_char:    last_reg};

endmodule

FILE: rtl/iam_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iam_merge
// Accumulates allele masks and, on the last character, merges them with the
// reference base into an IUPAC letter held in the result register.
// ----------------------------------------------------------------------------
module iam_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  iam_pkg::iam_stage_t stage,
    output logic                take,
    iam_out_if.source           result_out
);

    iam_pkg::base_mask_t acc_reg;
    iam_pkg::base_mask_t acc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    iam_pkg::char_t      merged_reg;
    logic                changed_reg;
    logic                differing_reg;

    iam_pkg::base_mask_t acc_or;
    iam_pkg::base_mask_t obs;
    iam_pkg::base_mask_t ref_mask;
    iam_pkg::char_t      ref_up;
    iam_pkg::char_t      code;
    iam_pkg::char_t      merged;
    logic                ambig;
    logic                in_rep;
    logic                chg;
    logic                emit;

    // a non-final beat always drains; a final one needs room in the result reg
    assign take = stage.valid &&
                  (!stage.last_char || !out_valid_reg || result_out.ready);
    assign emit = take && stage.last_char;

    // merge datapath
    always_comb
    begin
        acc_or   = acc_reg | stage.allele_mask;
        obs      = stage.minus_strand ? iam_pkg::swap_strand(acc_or) : acc_or;
        ref_up   = iam_pkg::to_upper(stage.ref_base);
        ref_mask = iam_pkg::decode_mask(stage.ref_base);
        ambig    = !(ref_up == iam_pkg::CHAR_UC_A || ref_up == iam_pkg::CHAR_UC_C ||
                     ref_up == iam_pkg::CHAR_UC_G || ref_up == iam_pkg::CHAR_UC_T);
        in_rep   = stage.ref_base >= iam_pkg::CHAR_LC_A &&
                   stage.ref_base <= iam_pkg::CHAR_LC_Z;
        code     = iam_pkg::CODE_TABLE[ref_mask | obs];
        chg      = code != ref_up;
        if (!chg)
            merged = stage.ref_base;
        else if (in_rep && code >= iam_pkg::CHAR_UC_A && code <= iam_pkg::CHAR_UC_Z)
            merged = code + iam_pkg::CASE_OFFSET;
        else
            merged = code;
    end

    // accumulator and result valid next state
    always_comb
    begin
        acc_next = acc_reg;
        if (take)
            acc_next = stage.last_char ? '0 : acc_or;
        if (emit)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            merged_reg    <= merged;
            changed_reg   <= chg;
            differing_reg <= ambig && (obs != ref_mask);
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.merged_base = merged_reg;
    assign result_out.changed     = changed_reg;
    assign result_out.differing   = differing_reg;

    // a final beat always produces a result beat
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("final beat did not load result register");

    // accumulator clears after a final beat
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> acc_reg == '0)
        else $error("accumulator not cleared after final beat");

    // accumulator only moves when a beat drains
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(acc_reg))
        else $error("accumulator changed without a beat");

    // no overwrite of a pending result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready |-> !emit)
        else $error("pending result overwritten");

endmodule

FILE: rtl/iupac_allele_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupac_allele_merge
// Merges an observed-allele string with a reference base into an IUPAC
// ambiguity letter.
// ----------------------------------------------------------------------------
// One character beat is accepted every cycle while no final beat is held up. Each
// beat is decoded in the input register stage, ORed into the allele mask accumulator
// in the merge stage, and the beat marked last_char loads the result register; a
// result is offered once its final character has passed both registers. A stalled
// result register holds up only final beats and the characters behind them; other
// characters keep flowing. The accumulator clears after every final beat.
module iupac_allele_merge (
    input  logic      clk,
    input  logic      rst_n,
    iam_in_if.sink    allele_in,
    iam_out_if.source result_out
);

    iam_pkg::iam_stage_t stage;
    logic                take;

    iam_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .allele_in (allele_in),
        .take      (take),
        .stage     (stage)
    );

    iam_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .take       (take),
        .result_out (result_out)
    );

endmodule
